// ===== src/hsc_pkg.sv =====
package hsc_pkg;

   localparam int unsigned WORD_BITS = 63;
   localparam int unsigned LEN_BITS = 6;
   localparam int unsigned SYN_BITS = 6;
   localparam int unsigned MAX_CODE_BITS = 63;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [LEN_BITS-1:0] len_type;
   typedef logic [SYN_BITS-1:0] syn_type;

   typedef struct packed {
      logic     decode_mode;
      len_type  bit_length;
      word_type bits;
   } s1_type;

   typedef struct packed {
      logic     decode_mode;
      len_type  bit_length;
      word_type bits;
      syn_type  syndrome;
      logic     enc_overflow;
      len_type  enc_length;
   } s2_type;

   typedef struct packed {
      word_type result_bits;
      len_type  result_length;
      len_type  corrected_position;
      logic     length_error;
   } rsp_type;

   // number of powers of two at or below p
   function automatic logic [2:0] pow2_count(input logic [6:0] p);
      logic [2:0] c;
      c = '0;
      for (int unsigned j = 0; j < 7; j++) begin
         if ((7'd1 << j) <= p) c = c + 3'd1;
      end
      return c;
   endfunction

   // parity bits needed for n data bits
   function automatic logic [2:0] parity_count(input len_type n);
      logic [2:0] r;
      logic       found;
      r = '0;
      found = 1'b0;
      for (int unsigned i = 0; i < 8; i++) begin
         if (!found && n != '0 && ((8'd1 << i) >= 8'(n) + 8'(i) + 8'd1)) begin
            r = 3'(i);
            found = 1'b1;
         end
      end
      return r;
   endfunction

   // code positions that have bit j set
   function automatic word_type pos_mask(input int unsigned j);
      word_type m;
      m = '0;
      for (int unsigned p = 1; p <= WORD_BITS; p++) begin
         m[p-1] = ((p >> j) & 1) != 0;
      end
      return m;
   endfunction

   function automatic word_type pow2_mask();
      word_type m;
      m = '0;
      for (int unsigned j = 0; j < SYN_BITS; j++) begin
         m[(1 << j) - 1] = 1'b1;
      end
      return m;
   endfunction

   function automatic syn_type syndrome(input word_type w);
      syn_type s;
      for (int unsigned j = 0; j < SYN_BITS; j++) begin
         s[j] = ^(w & pos_mask(j));
      end
      return s;
   endfunction

endpackage

// ===== src/hsc_req_if.sv =====
interface hsc_req_if import hsc_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type data_bits;
   len_type  bit_length;

   modport source (output valid, output data_bits, output bit_length, input ready);
   modport sink (input valid, input data_bits, input bit_length, output ready);
endinterface

// ===== src/hsc_rsp_if.sv =====
interface hsc_rsp_if import hsc_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type result_bits;
   len_type  result_length;
   len_type  corrected_position;
   logic     length_error;

   modport source (output valid, output result_bits, output result_length,
                   output corrected_position, output length_error, input ready);
   modport sink (input valid, input result_bits, input result_length,
                 input corrected_position, input length_error, output ready);
endinterface

// ===== src/hsc_csr_if.sv =====
interface hsc_csr_if ();
   logic valid;
   logic ready;
   logic decode_mode;

   modport source (output valid, output decode_mode, input ready);
   modport sink (input valid, input decode_mode, output ready);
endinterface

// ===== src/hsc_mask_stage.sv =====
module hsc_mask_stage import hsc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  logic     mode,
   input  word_type in_bits,
   input  len_type  in_length,
   output logic     out_valid,
   output s1_type   out_data,
   input  logic     out_ready
);

   logic     valid_ff, valid_in;
   s1_type   data_ff, data_in;
   word_type len_mask;

   assign in_ready = !valid_ff || out_ready;

   // length 63 wraps to all ones, length 0 gives an empty mask
   assign len_mask = (word_type'(1) << in_length) - word_type'(1);

   always_comb begin
      valid_in = in_ready ? in_valid : valid_ff;
      data_in = data_ff;
      if (in_ready && in_valid) begin
         data_in.decode_mode = mode;
         data_in.bit_length = in_length;
         data_in.bits = in_bits & len_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

// ===== src/hsc_syndrome_stage.sv =====
module hsc_syndrome_stage import hsc_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   in_valid,
   output logic   in_ready,
   input  s1_type in_data,
   output logic   out_valid,
   output s2_type out_data,
   input  logic   out_ready
);

   logic       valid_ff, valid_in;
   s2_type     data_ff, data_in;
   word_type   enc_word, sel_word;
   logic [6:0] code_len;

   // spread data bits over the positions that are not powers of two
   for (genvar p = 1; p <= WORD_BITS; p++) begin : g_scatter
      if ((p & (p - 1)) == 0) begin : g_parity
         assign enc_word[p-1] = 1'b0;
      end else begin : g_data
         localparam int K = p - int'(pow2_count(7'(p))) - 1;
         assign enc_word[p-1] = in_data.bits[K];
      end
   end

   assign sel_word = in_data.decode_mode ? in_data.bits : enc_word;
   assign code_len = {1'b0, in_data.bit_length} + {4'b0, parity_count(in_data.bit_length)};

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = in_ready ? in_valid : valid_ff;
      data_in = data_ff;
      if (in_ready && in_valid) begin
         data_in.decode_mode = in_data.decode_mode;
         data_in.bit_length = in_data.bit_length;
         data_in.bits = sel_word;
         data_in.syndrome = syndrome(sel_word);
         data_in.enc_overflow = code_len > 7'(MAX_CODE_BITS);
         data_in.enc_length = code_len[LEN_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

   // parity slots stay empty until the last stage fills them
   a_parity_slots_clear: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !data_ff.decode_mode |-> (data_ff.bits & pow2_mask()) == '0)
      else $error("encode word has data in a parity slot");

endmodule

// ===== src/hsc_finish_stage.sv =====
module hsc_finish_stage import hsc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  s2_type  in_data,
   output logic    out_valid,
   output rsp_type out_data,
   input  logic    out_ready
);

   localparam int DATA_MAX = WORD_BITS - int'(pow2_count(7'(WORD_BITS)));

   logic     valid_ff, valid_in;
   rsp_type  data_ff, data_in;
   word_type parity_word, enc_code, flip, fixed, extracted;
   logic     beyond, dec_too_long;
   len_type  dec_len;

   always_comb begin
      parity_word = '0;
      for (int unsigned j = 0; j < SYN_BITS; j++) begin
         parity_word[(1 << j) - 1] = in_data.syndrome[j];
      end
   end

   assign enc_code = in_data.bits | parity_word;

   // a syndrome past the word end is reported but not applied
   assign beyond = in_data.syndrome > in_data.bit_length;
   assign dec_too_long = {1'b0, in_data.bit_length} > 7'(MAX_CODE_BITS);

   always_comb begin
      for (int unsigned i = 0; i < WORD_BITS; i++) begin
         flip[i] = !beyond && (in_data.syndrome == SYN_BITS'(i + 1));
      end
   end

   assign fixed = in_data.bits ^ flip;

   for (genvar p = 1; p <= WORD_BITS; p++) begin : g_gather
      if ((p & (p - 1)) != 0) begin : g_data
         localparam int K = p - int'(pow2_count(7'(p))) - 1;
         assign extracted[K] = fixed[p-1];
      end
   end
   for (genvar k = DATA_MAX; k < WORD_BITS; k++) begin : g_tail
      assign extracted[k] = 1'b0;
   end

   assign dec_len = in_data.bit_length - {3'b0, pow2_count({1'b0, in_data.bit_length})};

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = in_ready ? in_valid : valid_ff;
      data_in = data_ff;
      if (in_ready && in_valid) begin
         data_in = '0;
         if (!in_data.decode_mode) begin
            if (in_data.enc_overflow) begin
               data_in.length_error = 1'b1;
            end else begin
               data_in.result_bits = enc_code;
               data_in.result_length = in_data.enc_length;
            end
         end else if (dec_too_long) begin
            data_in.length_error = 1'b1;
         end else begin
            data_in.result_bits = extracted;
            data_in.result_length = dec_len;
            data_in.corrected_position = in_data.syndrome;
            data_in.length_error = beyond;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

   a_codeword_checks: assert property (@(posedge clock) disable iff (reset)
      in_valid && !in_data.decode_mode && !in_data.enc_overflow
      |-> syndrome(enc_code) == '0)
      else $error("encoded word does not have a zero syndrome");

   a_error_clears_word: assert property (@(posedge clock) disable iff (reset)
      valid_ff && data_ff.length_error && data_ff.corrected_position == '0
      |-> data_ff.result_bits == '0 && data_ff.result_length == '0)
      else $error("length error without syndrome left a result word");

   a_bits_within_length: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (data_ff.result_bits >> data_ff.result_length) == '0)
      else $error("result has bits above its length");

endmodule

// ===== src/hamming_sec_codec.sv =====
// an accepted item passes through the mask, syndrome and finish stage registers in that order
// throughput: one item per cycle; mask, syndrome and finish stages each hold one item
// a stalled result holds the pipe in place, each stage refills as soon as it drains
// reset (synchronous, active high) empties all stages and sets decode_mode to encode
module hamming_sec_codec import hsc_pkg::*; (
   input logic       clock,
   input logic       reset,
   hsc_req_if.sink   req_ch,
   hsc_rsp_if.source rsp_ch,
   hsc_csr_if.sink   csr_ch
);

   logic    mode_ff, mode_in;
   logic    s1_valid, s1_ready, s2_valid, s2_ready;
   s1_type  s1_data;
   s2_type  s2_data;
   rsp_type rsp_data;

   assign csr_ch.ready = 1'b1;
   assign mode_in = (csr_ch.valid && csr_ch.ready) ? csr_ch.decode_mode : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   hsc_mask_stage u_mask (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .mode      (mode_ff),
      .in_bits   (req_ch.data_bits),
      .in_length (req_ch.bit_length),
      .out_valid (s1_valid),
      .out_data  (s1_data),
      .out_ready (s1_ready)
   );

   hsc_syndrome_stage u_syndrome (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_data  (s2_data),
      .out_ready (s2_ready)
   );

   hsc_finish_stage u_finish (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (rsp_ch.valid),
      .out_data  (rsp_data),
      .out_ready (rsp_ch.ready)
   );

   assign rsp_ch.result_bits = rsp_data.result_bits;
   assign rsp_ch.result_length = rsp_data.result_length;
   assign rsp_ch.corrected_position = rsp_data.corrected_position;
   assign rsp_ch.length_error = rsp_data.length_error;

endmodule

// ===== test/tb_hamming_sec_codec.sv =====
`timescale 1ns / 100ps

module tb_hamming_sec_codec import hsc_pkg::*; ();

   localparam int IDLE_LIMIT = 3000;
   localparam int HOLD_CYCLES = 60;

   class hamming_scoreboard;
      rsp_type pending_results[$];
      logic    decode_mode;
      int      mismatches;

      function new();
         decode_mode = 1'b0;
         mismatches = 0;
      endfunction

      function int unsigned position_xor(word_type w, int unsigned n);
         int unsigned s;
         s = 0;
         for (int unsigned p = 1; p <= n; p++) begin
            if (w[p-1]) s = s ^ p;
         end
         return s;
      endfunction

      function rsp_type hamming_result(logic decode, word_type bits, len_type n);
         rsp_type     r;
         word_type    v;
         int unsigned checks, total, k, s;
         r = '0;
         v = bits & ~(word_type'('1) << n);
         k = 0;
         if (!decode) begin
            checks = 0;
            if (n != 0) begin
               while ((1 << checks) < n + checks + 1) checks++;
            end
            total = n + checks;
            if (total > MAX_CODE_BITS) begin
               r.length_error = 1'b1;
            end else begin
               // data fill the positions that are not powers of two
               for (int unsigned p = 1; p <= total; p++) begin
                  if ((p & (p - 1)) != 0) begin
                     r.result_bits[p-1] = v[k];
                     k++;
                  end
               end
               s = position_xor(r.result_bits, total);
               for (int unsigned p = 1; p <= total; p = p << 1) begin
                  if ((s & p) != 0) r.result_bits[p-1] = 1'b1;
               end
               r.result_length = len_type'(total);
            end
         end else begin
            s = position_xor(v, n);
            // a syndrome past the end of the word is flagged, nothing flipped
            if (s > n) r.length_error = 1'b1;
            else if (s != 0) v[s-1] = ~v[s-1];
            r.corrected_position = len_type'(s);
            for (int unsigned p = 1; p <= n; p++) begin
               if ((p & (p - 1)) != 0) begin
                  r.result_bits[k] = v[p-1];
                  k++;
               end
            end
            r.result_length = len_type'(k);
         end
         return r;
      endfunction

      function void set_mode(logic m);
         decode_mode = m;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      function void note_item(word_type bits, len_type n);
         pending_results.push_back(hamming_result(decode_mode, bits, n));
      endfunction

      task report_mismatch(string msg);
         $display("%0t ns: %s", $time, msg);
         mismatches++;
      endtask

      task check_result(word_type bits, len_type len, len_type pos, logic lerr);
         rsp_type want;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result with no item outstanding, bits %h", bits));
            return;
         end
         want = pending_results.pop_front();
         if (bits !== want.result_bits)
            report_mismatch($sformatf("result_bits %h, want %h", bits, want.result_bits));
         if (len !== want.result_length)
            report_mismatch($sformatf("result_length %0d, want %0d", len,
                                      want.result_length));
         if (pos !== want.corrected_position)
            report_mismatch($sformatf("corrected_position %0d, want %0d", pos,
                                      want.corrected_position));
         if (lerr !== want.length_error)
            report_mismatch($sformatf("length_error %b, want %b", lerr,
                                      want.length_error));
      endtask
   endclass

   logic clock;
   logic reset;

   hsc_req_if req_bus ();
   hsc_rsp_if rsp_bus ();
   hsc_csr_if csr_bus ();

   hamming_sec_codec uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   hamming_scoreboard sb;
   bit quiet = 1'b0;
   bit hold_pending = 1'b0;
   bit offering = 1'b0;
   int idle_cycles = 0;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic int pick_gap();
      int unsigned r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic word_type random_word();
      return word_type'({$urandom(), $urandom()});
   endfunction

   task automatic send_item(word_type bits, len_type n);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         if (offering) req_bus.valid <= 1'b0;
         offering = 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data_bits <= bits;
      req_bus.bit_length <= n;
      offering = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_item(bits, n);
   endtask

   task automatic drain();
      if (offering) req_bus.valid <= 1'b0;
      offering = 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_mode(logic m);
      drain();
      csr_bus.valid <= 1'b1;
      csr_bus.decode_mode <= m;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      sb.set_mode(m);
   endtask

   task automatic random_encode(output word_type bits, output len_type n);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 5) n = '0;
      else if (pick < 15) n = len_type'($urandom_range(58, 63));
      else if (pick < 22) n = len_type'(57);
      else n = len_type'($urandom_range(1, 57));
      bits = random_word();
   endtask

   // mostly real codewords with zero, one or two flipped bits, the rest noise
   task automatic random_decode(output word_type bits, output len_type n);
      rsp_type     cw;
      int unsigned pick, spot;
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
         cw = sb.hamming_result(1'b0, random_word(), len_type'($urandom_range(1, 57)));
         bits = cw.result_bits;
         n = cw.result_length;
         if ($urandom_range(0, 9) < 7) begin
            spot = $urandom_range(1, n) - 1;
            bits[spot] = ~bits[spot];
         end
         if (pick < 10) begin
            spot = $urandom_range(1, n) - 1;
            bits[spot] = ~bits[spot];
         end
         if ($urandom_range(0, 1) == 1) bits = bits | (random_word() & (word_type'('1) << n));
      end else begin
         n = len_type'($urandom_range(0, 63));
         bits = random_word();
      end
   endtask

   task automatic run_random(logic mode, int count, bit calm, bit squeeze);
      word_type bits;
      len_type  n;
      write_mode(mode);
      quiet = calm;
      for (int i = 0; i < count; i++) begin
         if (squeeze && i == 20) hold_pending = 1'b1;
         if (mode) random_decode(bits, n);
         else random_encode(bits, n);
         send_item(bits, n);
      end
   endtask

   // result side: random stalls, plus one long hold-off on request
   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_result(rsp_bus.result_bits, rsp_bus.result_length,
                         rsp_bus.corrected_position, rsp_bus.length_error);
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_hamming_sec_codec: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      rsp_type cw7, cw63;
      sb = new();
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.data_bits = '0;
      req_bus.bit_length = '0;
      csr_bus.valid = 1'b0;
      csr_bus.decode_mode = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      write_mode(1'b0);
      send_item('1, 6'd0);
      send_item(63'h1, 6'd1);
      send_item(63'hB, 6'd4);
      send_item('1, 6'd57);
      send_item('0, 6'd57);
      send_item('1, 6'd58);
      send_item('1, 6'd63);
      send_item('1, 6'd11);
      send_item(word_type'(64'h5555_5555_5555_5555), 6'd26);

      cw7 = sb.hamming_result(1'b0, 63'hB, 6'd4);
      cw63 = sb.hamming_result(1'b0, '1, 6'd57);
      write_mode(1'b1);
      send_item('1, 6'd0);
      send_item(cw7.result_bits, 6'd7);
      send_item(cw7.result_bits ^ (63'd1 << 4), 6'd7);
      send_item(cw7.result_bits ^ (63'd1 << 3), 6'd7);
      send_item(cw7.result_bits | (word_type'('1) << 7), 6'd7);
      send_item(cw63.result_bits, 6'd63);
      send_item(cw63.result_bits ^ (63'd1 << 62), 6'd63);
      send_item('1, 6'd63);
      send_item('0, 6'd63);
      // positions 3 and 4 give a syndrome of 7 in a 5-bit word
      send_item(63'b01100, 6'd5);
      send_item(63'b1, 6'd1);
      send_item(63'b11, 6'd2);

      run_random(1'b0, 150, 1'b0, 1'b0);
      run_random(1'b1, 200, 1'b0, 1'b1);
      run_random(1'b0, 100, 1'b1, 1'b1);
      run_random(1'b1, 150, 1'b1, 1'b0);
      run_random(1'b0, 100, 1'b0, 1'b0);

      drain();
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("tb_hamming_sec_codec: PASS");
      end else begin
         $display("tb_hamming_sec_codec: FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/hsc_pkg.sv
src/hsc_req_if.sv
src/hsc_rsp_if.sv
src/hsc_csr_if.sv
src/hsc_mask_stage.sv
src/hsc_syndrome_stage.sv
src/hsc_finish_stage.sv
src/hamming_sec_codec.sv
test/tb_hamming_sec_codec.sv
